@@ hdl/rars_pkg.sv @@
package rars_pkg;

	// Table depth the register file always carries; LEVELS selects how many are compared.
	localparam int unsigned MAX_LEVELS = 3;
	localparam int unsigned LEVELS_DEFAULT = 3;

	localparam int unsigned RATE_W = 8;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned HOLD_W = 14;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W = 48;
	localparam int unsigned OUT_DATA_W = 24;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FPS   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_A   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_B   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_C   = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_A    = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_B    = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_C    = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_HOLD = 8'd7;

	// Reset values.
	localparam logic [RATE_W-1:0] MAX_FPS_RST = 8'd60;
	localparam logic [LIMIT_W-1:0] LIMIT_A_RST = 16'd100;
	localparam logic [LIMIT_W-1:0] LIMIT_B_RST = 16'd200;
	localparam logic [LIMIT_W-1:0] LIMIT_C_RST = 16'd400;
	localparam logic [RATE_W-1:0] RATE_A_RST = 8'd30;
	localparam logic [RATE_W-1:0] RATE_B_RST = 8'd20;
	localparam logic [RATE_W-1:0] RATE_C_RST = 8'd10;
	localparam logic [HOLD_W-1:0] INIT_HOLD_RST = 14'd1000;

	// Timing constants.
	localparam logic [TIME_W-1:0] RELAPSE_MS = 32'd5000;
	localparam logic [TIME_W-1:0] GOOD_SPAN_MS = 32'd5000;
	localparam logic [HOLD_W:0] HOLD_CAP_MS = 15'd10000;
	localparam logic [HOLD_W-1:0] HOLD_FLOOR_MS = 14'd1000;

	typedef struct packed {
		logic [RATE_W-1:0] max_fps;
		logic [MAX_LEVELS-1:0][LIMIT_W-1:0] rtt_limit;
		logic [MAX_LEVELS-1:0][RATE_W-1:0] rate_at;
	} cfg_t;

	// now_ms sits in the low bits of the input transfer, rtt_ms above it.
	typedef struct packed {
		logic [LIMIT_W-1:0] rtt_ms;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic was_bad;
		logic [HOLD_W-1:0] hold_ms;
		logic [RATE_W-1:0] send_rate;
	} result_t;

endpackage

@@ hdl/rars_regs.sv @@
module rars_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rars_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rars_pkg::CFG_DATA_W-1:0] cfg_data,
	output rars_pkg::cfg_t cfg
);

	rars_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_fps <= rars_pkg::MAX_FPS_RST;
			cfg_q.rtt_limit[0] <= rars_pkg::LIMIT_A_RST;
			cfg_q.rtt_limit[1] <= rars_pkg::LIMIT_B_RST;
			cfg_q.rtt_limit[2] <= rars_pkg::LIMIT_C_RST;
			cfg_q.rate_at[0] <= rars_pkg::RATE_A_RST;
			cfg_q.rate_at[1] <= rars_pkg::RATE_B_RST;
			cfg_q.rate_at[2] <= rars_pkg::RATE_C_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rars_pkg::REG_MAX_FPS: cfg_q.max_fps <= cfg_data[rars_pkg::RATE_W-1:0];
				rars_pkg::REG_LIMIT_A: cfg_q.rtt_limit[0] <= cfg_data;
				rars_pkg::REG_LIMIT_B: cfg_q.rtt_limit[1] <= cfg_data;
				rars_pkg::REG_LIMIT_C: cfg_q.rtt_limit[2] <= cfg_data;
				rars_pkg::REG_RATE_A: cfg_q.rate_at[0] <= cfg_data[rars_pkg::RATE_W-1:0];
				rars_pkg::REG_RATE_B: cfg_q.rate_at[1] <= cfg_data[rars_pkg::RATE_W-1:0];
				rars_pkg::REG_RATE_C: cfg_q.rate_at[2] <= cfg_data[rars_pkg::RATE_W-1:0];
				// initial hold only matters at reset, where it is the constant anyway
				rars_pkg::REG_INIT_HOLD: ;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/rars_core.sv @@
module rars_core #(
	parameter int unsigned LEVELS = rars_pkg::LEVELS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  rars_pkg::sample_t sample,
	input  rars_pkg::cfg_t cfg,
	output rars_pkg::result_t result
);

	localparam int unsigned TW = rars_pkg::TIME_W;
	localparam int unsigned HW = rars_pkg::HOLD_W;
	localparam int unsigned RW = rars_pkg::RATE_W;

	logic [RW-1:0] rate_q;
	logic [HW-1:0] hold_q;
	logic [TW-1:0] deadline_q;
	logic armed_q;
	logic bad_seen_q;
	logic [TW-1:0] last_bad_q;
	logic good_seen_q;
	logic [TW-1:0] good_since_q;

	logic bad;
	logic [rars_pkg::LIMIT_W-1:0] best_thr;
	logic [RW-1:0] best_rate;
	logic [TW-1:0] since_bad, since_good, past_deadline;
	logic expired, relapse;
	logic [HW:0] hold_dbl;
	logic [HW-1:0] hold_half;

	logic [RW-1:0] rate_d;
	logic [HW-1:0] hold_d;
	logic [TW-1:0] deadline_d, last_bad_d, good_since_d;
	logic armed_d, bad_seen_d, good_seen_d;

	// Largest threshold met wins; ties keep the lower entry.
	always_comb begin
		bad = 1'b0;
		best_thr = '0;
		best_rate = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (sample.rtt_ms >= cfg.rtt_limit[i]) begin
				if (!bad || cfg.rtt_limit[i] > best_thr) begin
					best_thr = cfg.rtt_limit[i];
					best_rate = cfg.rate_at[i];
				end
				bad = 1'b1;
			end
		end
	end

	assign since_bad = sample.now_ms - last_bad_q;
	assign since_good = sample.now_ms - good_since_q;
	assign past_deadline = sample.now_ms - deadline_q;
	assign expired = !armed_q || !past_deadline[TW-1];
	assign relapse = (rate_q != cfg.max_fps) && bad_seen_q && (since_bad < rars_pkg::RELAPSE_MS);
	assign hold_dbl = {hold_q, 1'b0};
	assign hold_half = {1'b0, hold_q[HW-1:1]};

	always_comb begin
		rate_d = rate_q;
		hold_d = hold_q;
		deadline_d = deadline_q;
		armed_d = armed_q;
		bad_seen_d = bad_seen_q;
		last_bad_d = last_bad_q;
		good_seen_d = good_seen_q;
		good_since_d = good_since_q;
		if (bad) begin
			if (relapse) begin
				hold_d = (hold_dbl < rars_pkg::HOLD_CAP_MS) ? hold_dbl[HW-1:0]
					: rars_pkg::HOLD_CAP_MS[HW-1:0];
			end
			deadline_d = sample.now_ms + TW'(hold_d);
			armed_d = 1'b1;
			bad_seen_d = 1'b1;
			last_bad_d = sample.now_ms;
			good_seen_d = 1'b0;
			if (best_rate < rate_q) begin
				rate_d = best_rate;
			end
		end else if (expired) begin
			armed_d = 1'b0;
			rate_d = cfg.max_fps;
			if (!good_seen_q) begin
				good_seen_d = 1'b1;
				good_since_d = sample.now_ms;
			end else if (since_good > rars_pkg::GOOD_SPAN_MS) begin
				hold_d = (hold_half > rars_pkg::HOLD_FLOOR_MS) ? hold_half
					: rars_pkg::HOLD_FLOOR_MS;
				good_since_d = sample.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= rars_pkg::MAX_FPS_RST;
			hold_q <= rars_pkg::INIT_HOLD_RST;
			deadline_q <= '0;
			armed_q <= 1'b0;
			bad_seen_q <= 1'b0;
			last_bad_q <= '0;
			good_seen_q <= 1'b0;
			good_since_q <= '0;
		end else if (fire) begin
			rate_q <= rate_d;
			hold_q <= hold_d;
			deadline_q <= deadline_d;
			armed_q <= armed_d;
			bad_seen_q <= bad_seen_d;
			last_bad_q <= last_bad_d;
			good_seen_q <= good_seen_d;
			good_since_q <= good_since_d;
		end
	end

	assign result.was_bad = bad;
	assign result.hold_ms = hold_d;
	assign result.send_rate = rate_d;

	hold_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q >= rars_pkg::HOLD_FLOOR_MS && {1'b0, hold_q} <= rars_pkg::HOLD_CAP_MS)
		else $error("hold duration left its 1000..10000 ms range");

	bad_arms_deadline: assert property (@(posedge clk) disable iff (!arst_n)
		fire && bad |=> armed_q && bad_seen_q && !good_seen_q)
		else $error("bad sample did not arm the recovery deadline");

	good_run_keeps_rate: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !bad && !expired |=> $stable(rate_q) && $stable(hold_q))
		else $error("good sample before deadline changed rate or hold");

endmodule

@@ hdl/rtt_adaptive_rate_selector.sv @@
// RTT-driven send-rate selector.
//
// s_axis carries one sample per transfer: tdata[31:0] now_ms (wrapping ms clock),
// tdata[47:32] rtt_ms. m_axis returns exactly one result per sample: tdata[7:0]
// send_rate, tdata[21:8] hold_ms, tdata[22] was_bad, tdata[23] zero.
// cfg writes one register per transfer (cfg_index 0..7, data in the low bits of
// cfg_data); cfg_ready is always high and indexes past seven are dropped. Write
// registers only while no sample is in flight.
//
// A sample waits in the input register until the result register, which drives m_axis,
// is free. Throughput: one sample per cycle while the receiver keeps up; the rate/hold
// update is a single pass of compares and a 32-bit add between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample; s_axis_tready drops only when both are full.
//
// Reset (arst_n low) loads the register defaults, sets the rate to 60 fps and the
// hold to 1000 ms, disarms the recovery deadline and empties both stages.
module rtt_adaptive_rate_selector #(
	parameter int unsigned LEVELS = rars_pkg::LEVELS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [31:0] now_ms, [47:32] rtt_ms
	input  logic [rars_pkg::IN_DATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [7:0] send_rate, [21:8] hold_ms, [22] was_bad, [23] zero fill
	output logic [rars_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rars_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rars_pkg::CFG_DATA_W-1:0] cfg_data
);

	rars_pkg::cfg_t cfg;
	rars_pkg::sample_t sample_s1;
	rars_pkg::result_t result;
	rars_pkg::result_t result_q;
	logic valid_s1;
	logic out_valid_q;
	logic advance;

	assign cfg_ready = 1'b1;

	rars_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move the held sample into the result register whenever that slot frees up.
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload: capture on every input transfer.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= s_axis_tdata;
		end
	end

	rars_core #(
		.LEVELS (LEVELS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, result_q};

	advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("sample left the input stage without reaching the output");

	stalled_sample_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(sample_s1))
		else $error("stalled sample dropped or changed in the input stage");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int NUM_REGS = int'(rars_pkg::REG_INIT_HOLD) + 1;
	// Longest run of cycles with no transfer on any channel before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 5000;
	// Margin for the pipe to settle once every decision is back.
	localparam int SETTLE_CYCLES = 3;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_pattern_t;
	typedef enum {CFG_SORTED, CFG_LOW_EXTREME, CFG_UNSORTED, CFG_HIGH_EXTREME,
		CFG_DEFAULTS} cfg_kind_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// [31:0] now_ms, [47:32] rtt_ms
	logic [rars_pkg::IN_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// [7:0] send_rate, [21:8] hold_ms, [22] was_bad, [23] zero fill
	logic [rars_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [rars_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rars_pkg::CFG_DATA_W-1:0] cfg_data;

	rtt_adaptive_rate_selector uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the register file, as the block should hold it.
	logic [rars_pkg::RATE_W-1:0] cfg_max_fps;
	logic [rars_pkg::LIMIT_W-1:0] cfg_limit [rars_pkg::MAX_LEVELS];
	logic [rars_pkg::RATE_W-1:0] cfg_rate [rars_pkg::MAX_LEVELS];
	logic [rars_pkg::HOLD_W-1:0] cfg_init_hold;

	// Shadow copy of the rate selector state.
	logic [rars_pkg::RATE_W-1:0] st_rate;
	logic [rars_pkg::HOLD_W-1:0] st_hold;
	logic [rars_pkg::TIME_W-1:0] st_deadline;
	bit st_armed;
	bit st_bad_seen;
	logic [rars_pkg::TIME_W-1:0] st_last_bad;
	bit st_good_seen;
	logic [rars_pkg::TIME_W-1:0] st_good_since;

	// Register values for the next configuration pass, indexed by register index.
	logic [rars_pkg::CFG_DATA_W-1:0] cfg_plan [NUM_REGS];

	rars_pkg::result_t expected_decisions [$];
	int error_count = 0;
	int idle_cycles = 0;

	// Sender pacing and random traffic state.
	int unsigned burst_left = 0;
	bit gaps_enabled = 1'b1;
	bit hold_off_request = 1'b0;
	bit congested = 1'b0;
	logic [rars_pkg::TIME_W-1:0] clock_ms = '0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Work out the decision for one sample and advance the shadow state.
	function automatic rars_pkg::result_t predict_rate_update(
		input logic [rars_pkg::TIME_W-1:0] now,
		input logic [rars_pkg::LIMIT_W-1:0] rtt);
		rars_pkg::result_t r;
		bit bad;
		logic [rars_pkg::LIMIT_W-1:0] best_limit;
		logic [rars_pkg::RATE_W-1:0] best_rate;
		logic [rars_pkg::HOLD_W:0] doubled;
		logic [rars_pkg::HOLD_W-1:0] halved;
		logic [rars_pkg::TIME_W-1:0] past_deadline;
		int i;
		bad = 1'b0;
		best_limit = '0;
		best_rate = '0;
		// Largest threshold met wins; on a tie the lower entry keeps it (strict >).
		for (i = 0; i < int'(rars_pkg::LEVELS_DEFAULT); i++) begin
			if (rtt >= cfg_limit[i]) begin
				if (!bad || cfg_limit[i] > best_limit) begin
					best_limit = cfg_limit[i];
					best_rate = cfg_rate[i];
				end
				bad = 1'b1;
			end
		end
		if (bad) begin
			// Relapse while reduced: double the hold, capped.
			if (st_rate != cfg_max_fps && st_bad_seen &&
				(now - st_last_bad) < rars_pkg::RELAPSE_MS) begin
				doubled = {st_hold, 1'b0};
				st_hold = (doubled < rars_pkg::HOLD_CAP_MS) ? doubled[rars_pkg::HOLD_W-1:0]
					: rars_pkg::HOLD_W'(rars_pkg::HOLD_CAP_MS);
			end
			st_deadline = now + rars_pkg::TIME_W'(st_hold);
			st_armed = 1'b1;
			st_bad_seen = 1'b1;
			st_last_bad = now;
			st_good_seen = 1'b0;
			if (best_rate < st_rate)
				st_rate = best_rate;
		end else begin
			// Deadline counts as expired once now is at or past it, read as signed.
			past_deadline = now - st_deadline;
			if (!st_armed || !past_deadline[rars_pkg::TIME_W-1]) begin
				st_armed = 1'b0;
				st_rate = cfg_max_fps;
				if (!st_good_seen) begin
					st_good_seen = 1'b1;
					st_good_since = now;
				end else if ((now - st_good_since) > rars_pkg::GOOD_SPAN_MS) begin
					halved = st_hold >> 1;
					st_hold = (halved > rars_pkg::HOLD_FLOOR_MS) ? halved
						: rars_pkg::HOLD_FLOOR_MS;
					st_good_since = now;
				end
			end
		end
		r.send_rate = st_rate;
		r.hold_ms = st_hold;
		r.was_bad = bad;
		return r;
	endfunction

	// Mirror one register write; indexes past the table are dropped.
	function automatic void store_register(input logic [rars_pkg::CFG_IDX_W-1:0] idx,
		input logic [rars_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			rars_pkg::REG_MAX_FPS: cfg_max_fps = value[rars_pkg::RATE_W-1:0];
			rars_pkg::REG_LIMIT_A: cfg_limit[0] = value[rars_pkg::LIMIT_W-1:0];
			rars_pkg::REG_LIMIT_B: cfg_limit[1] = value[rars_pkg::LIMIT_W-1:0];
			rars_pkg::REG_LIMIT_C: cfg_limit[2] = value[rars_pkg::LIMIT_W-1:0];
			rars_pkg::REG_RATE_A: cfg_rate[0] = value[rars_pkg::RATE_W-1:0];
			rars_pkg::REG_RATE_B: cfg_rate[1] = value[rars_pkg::RATE_W-1:0];
			rars_pkg::REG_RATE_C: cfg_rate[2] = value[rars_pkg::RATE_W-1:0];
			rars_pkg::REG_INIT_HOLD: cfg_init_hold = value[rars_pkg::HOLD_W-1:0];
			default: ;
		endcase
	endfunction

	// Offer one sample and hold it until the block takes it. The valid is left high
	// afterwards so back-to-back samples never drop it for a cycle.
	task automatic offer_sample(input logic [rars_pkg::TIME_W-1:0] now,
		input logic [rars_pkg::LIMIT_W-1:0] rtt);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = gaps_enabled ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata <= {rtt, now};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_decisions.push_back(predict_rate_update(now, rtt));
	endtask

	// Drop valid and hold until every decision is back, then let the pipe settle.
	task automatic wait_until_quiet;
		s_axis_tvalid <= 1'b0;
		while (expected_decisions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write every register from cfg_plan, optionally followed by a write past the table.
	task automatic load_config(input bit add_stray,
		input logic [rars_pkg::CFG_IDX_W-1:0] stray_index);
		int i;
		logic [rars_pkg::CFG_IDX_W-1:0] idx;
		logic [rars_pkg::CFG_DATA_W-1:0] value;
		for (i = 0; i < NUM_REGS + int'(add_stray); i++) begin
			idx = (i < NUM_REGS) ? rars_pkg::CFG_IDX_W'(i) : stray_index;
			value = (i < NUM_REGS) ? cfg_plan[i] : rars_pkg::CFG_DATA_W'($urandom);
			cfg_index <= idx;
			cfg_data <= value;
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			store_register(idx, value);
		end
		cfg_valid <= 1'b0;
	endtask

	// Traffic that mostly looks like a real link: time moves forward in modest steps
	// and the rtt sits near the thresholds during congestion, clear of them otherwise.
	task automatic offer_random_sample;
		int unsigned pick;
		int unsigned k;
		logic [rars_pkg::LIMIT_W:0] near;
		logic [rars_pkg::LIMIT_W-1:0] rtt;
		logic [rars_pkg::LIMIT_W-1:0] lowest;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			clock_ms = $urandom;
		else if (pick < 4)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 12000);
		else if (pick < 64)
			clock_ms += $urandom_range(0, 400);
		else if (pick < 90)
			clock_ms += $urandom_range(400, 3000);
		else
			clock_ms += $urandom_range(3000, 12000);
		if ($urandom_range(0, 99) < 12)
			congested = !congested;
		lowest = cfg_limit[0];
		if (cfg_limit[1] < lowest)
			lowest = cfg_limit[1];
		if (cfg_limit[2] < lowest)
			lowest = cfg_limit[2];
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			rtt = rars_pkg::LIMIT_W'($urandom);
		end else if (pick == 1) begin
			rtt = '1;
		end else if (pick == 2) begin
			rtt = '0;
		end else if (congested) begin
			k = $urandom_range(0, rars_pkg::MAX_LEVELS - 1);
			near = {1'b0, cfg_limit[k]} + (rars_pkg::LIMIT_W + 1)'($urandom_range(0, 40));
			rtt = near[rars_pkg::LIMIT_W] ? '1 : near[rars_pkg::LIMIT_W-1:0];
		end else if (lowest == 0) begin
			rtt = '0;
		end else if ($urandom_range(0, 3) == 0) begin
			rtt = lowest - 1'b1;
		end else begin
			rtt = rars_pkg::LIMIT_W'($urandom_range(0, lowest - 1));
		end
		offer_sample(clock_ms, rtt);
	endtask

	// Walk up the reset table one threshold at a time, back to back in time, so the
	// hold doubles on every relapse until it hits the cap.
	task automatic test_thresholds;
		offer_sample(32'd0, 16'd0);
		offer_sample(32'd1, 16'd99);
		offer_sample(32'd2, 16'd100);
		offer_sample(32'd3, 16'd199);
		offer_sample(32'd4, 16'd200);
		offer_sample(32'd5, 16'd399);
		offer_sample(32'd6, 16'd400);
		offer_sample(32'd7, 16'hFFFF);
	endtask

	// Deadline edges, halving down to the floor, relapse window edge and time wrap.
	task automatic test_hold_timing;
		offer_sample(32'd8, 16'd0);
		// exactly at the deadline counts as expired
		offer_sample(32'd10007, 16'd0);
		// exactly one good span is not enough to halve
		offer_sample(32'd15007, 16'd0);
		offer_sample(32'd15008, 16'd0);
		offer_sample(32'd20009, 16'd0);
		offer_sample(32'd25010, 16'd0);
		// halving lands below the floor here
		offer_sample(32'd30011, 16'd0);
		offer_sample(32'd35013, 16'd150);
		// a gap of exactly the relapse window does not double
		offer_sample(32'd40013, 16'd150);
		offer_sample(32'hFFFF_FF00, 16'd500);
		// relapse measured across the wrap of the ms clock
		offer_sample(32'h0000_0100, 16'd500);
		offer_sample(32'h0000_0800, 16'd0);
		offer_sample(32'h0000_08D0, 16'd0);
	endtask

	// Thresholds out of order, tied thresholds, a zero threshold, rate and hold
	// extremes, and writes to indexes past the register file.
	task automatic test_register_extremes;
		wait_until_quiet();
		cfg_plan[rars_pkg::REG_MAX_FPS] = 16'd255;
		cfg_plan[rars_pkg::REG_LIMIT_A] = 16'd500;
		cfg_plan[rars_pkg::REG_LIMIT_B] = 16'd500;
		cfg_plan[rars_pkg::REG_LIMIT_C] = 16'd0;
		cfg_plan[rars_pkg::REG_RATE_A] = 16'd7;
		cfg_plan[rars_pkg::REG_RATE_B] = 16'd9;
		cfg_plan[rars_pkg::REG_RATE_C] = 16'd1;
		cfg_plan[rars_pkg::REG_INIT_HOLD] = 16'd10000;
		load_config(1'b1, rars_pkg::REG_INIT_HOLD + 1'b1);
		offer_sample(32'h0000_1000, 16'd600);
		offer_sample(32'h0000_1001, 16'd0);
		wait_until_quiet();
		cfg_plan[rars_pkg::REG_MAX_FPS] = 16'd1;
		cfg_plan[rars_pkg::REG_LIMIT_A] = 16'hFFFF;
		cfg_plan[rars_pkg::REG_LIMIT_B] = 16'hFFFF;
		cfg_plan[rars_pkg::REG_LIMIT_C] = 16'hFFFF;
		cfg_plan[rars_pkg::REG_RATE_A] = 16'd255;
		cfg_plan[rars_pkg::REG_RATE_B] = 16'd255;
		cfg_plan[rars_pkg::REG_RATE_C] = 16'd255;
		cfg_plan[rars_pkg::REG_INIT_HOLD] = 16'd1000;
		load_config(1'b1, '1);
		offer_sample(32'h0000_3000, 16'hFFFE);
		offer_sample(32'h0000_8000, 16'hFFFF);
		offer_sample(32'h0001_0000, 16'hFFFE);
	endtask

	// Several register settings in turn, each followed by a stretch of random traffic.
	task automatic test_random_traffic;
		int phase;
		int n;
		int i;
		cfg_kind_t kind;
		logic [rars_pkg::LIMIT_W-1:0] lim [rars_pkg::MAX_LEVELS];
		logic [rars_pkg::LIMIT_W-1:0] tmp;
		clock_ms = $urandom;
		for (phase = 0; phase < 6; phase++) begin
			wait_until_quiet();
			kind = cfg_kind_t'(phase % 5);
			for (i = 0; i < rars_pkg::MAX_LEVELS; i++) begin
				lim[i] = (kind == CFG_UNSORTED) ? rars_pkg::LIMIT_W'($urandom)
					: rars_pkg::LIMIT_W'($urandom_range(0, 3000));
				cfg_plan[rars_pkg::REG_RATE_A + i] =
					rars_pkg::CFG_DATA_W'($urandom_range(1, 255));
			end
			if (kind == CFG_SORTED) begin
				if (lim[0] > lim[1]) begin tmp = lim[0]; lim[0] = lim[1]; lim[1] = tmp; end
				if (lim[1] > lim[2]) begin tmp = lim[1]; lim[1] = lim[2]; lim[2] = tmp; end
				if (lim[0] > lim[1]) begin tmp = lim[0]; lim[0] = lim[1]; lim[1] = tmp; end
			end
			for (i = 0; i < rars_pkg::MAX_LEVELS; i++)
				cfg_plan[rars_pkg::REG_LIMIT_A + i] = lim[i];
			cfg_plan[rars_pkg::REG_MAX_FPS] = rars_pkg::CFG_DATA_W'($urandom_range(1, 255));
			cfg_plan[rars_pkg::REG_INIT_HOLD] =
				rars_pkg::CFG_DATA_W'($urandom_range(1000, 10000));
			case (kind)
				CFG_LOW_EXTREME: begin
					// first threshold at zero: every sample is bad
					cfg_plan[rars_pkg::REG_MAX_FPS] = 16'd255;
					cfg_plan[rars_pkg::REG_LIMIT_A] = 16'd0;
					cfg_plan[rars_pkg::REG_LIMIT_B] = 16'd1;
					cfg_plan[rars_pkg::REG_LIMIT_C] = 16'hFFFF;
					cfg_plan[rars_pkg::REG_RATE_A] = 16'd255;
					cfg_plan[rars_pkg::REG_RATE_B] = 16'd128;
					cfg_plan[rars_pkg::REG_RATE_C] = 16'd1;
					cfg_plan[rars_pkg::REG_INIT_HOLD] = 16'd1000;
				end
				CFG_HIGH_EXTREME: begin
					cfg_plan[rars_pkg::REG_MAX_FPS] = 16'd255;
					cfg_plan[rars_pkg::REG_LIMIT_A] = 16'hFFFF;
					cfg_plan[rars_pkg::REG_LIMIT_B] = 16'hFFFF;
					cfg_plan[rars_pkg::REG_LIMIT_C] = 16'hFFFF;
					cfg_plan[rars_pkg::REG_RATE_A] = 16'd1;
					cfg_plan[rars_pkg::REG_RATE_B] = 16'd255;
					cfg_plan[rars_pkg::REG_RATE_C] = 16'd128;
					cfg_plan[rars_pkg::REG_INIT_HOLD] = 16'd10000;
				end
				CFG_DEFAULTS: begin
					cfg_plan[rars_pkg::REG_MAX_FPS] =
						rars_pkg::CFG_DATA_W'(rars_pkg::MAX_FPS_RST);
					cfg_plan[rars_pkg::REG_LIMIT_A] = rars_pkg::LIMIT_A_RST;
					cfg_plan[rars_pkg::REG_LIMIT_B] = rars_pkg::LIMIT_B_RST;
					cfg_plan[rars_pkg::REG_LIMIT_C] = rars_pkg::LIMIT_C_RST;
					cfg_plan[rars_pkg::REG_RATE_A] =
						rars_pkg::CFG_DATA_W'(rars_pkg::RATE_A_RST);
					cfg_plan[rars_pkg::REG_RATE_B] =
						rars_pkg::CFG_DATA_W'(rars_pkg::RATE_B_RST);
					cfg_plan[rars_pkg::REG_RATE_C] =
						rars_pkg::CFG_DATA_W'(rars_pkg::RATE_C_RST);
					cfg_plan[rars_pkg::REG_INIT_HOLD] =
						rars_pkg::CFG_DATA_W'(rars_pkg::INIT_HOLD_RST);
				end
				default: ;
			endcase
			load_config(1'b1, rars_pkg::CFG_IDX_W'($urandom_range(NUM_REGS, 255)));
			// one phase runs the sender flat out
			gaps_enabled = (phase != 2);
			for (n = 0; n < 100; n++)
				offer_random_sample();
		end
		gaps_enabled = 1'b1;
	endtask

	// Have the receiver hold off for a long stretch while samples keep coming, so
	// both stages fill and the input side has to stall.
	task automatic test_backpressure;
		int n;
		wait_until_quiet();
		hold_off_request = 1'b1;
		gaps_enabled = 1'b0;
		for (n = 0; n < 30; n++)
			offer_random_sample();
		gaps_enabled = 1'b1;
	endtask

	// Receiver: cycle through ready patterns of random length, and honor a hold-off
	// request with a long stall counted here.
	initial begin
		rx_pattern_t pattern;
		int unsigned span;
		int unsigned beat;
		m_axis_tready <= 1'b0;
		pattern = RX_ALWAYS;
		span = 0;
		beat = 0;
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(200, 320)) @(posedge clk);
			end
			if (span == 0) begin
				pattern = rx_pattern_t'($urandom_range(0, 3));
				span = $urandom_range(16, 160);
			end
			span--;
			beat++;
			case (pattern)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
				RX_PERIODIC: m_axis_tready <= ((beat % 5) < 2);
				default: m_axis_tready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// Compare each result transfer with the oldest outstanding decision.
	always @(posedge clk) begin
		rars_pkg::result_t got;
		rars_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = rars_pkg::result_t'(m_axis_tdata[$bits(rars_pkg::result_t)-1:0]);
			if (expected_decisions.size() == 0) begin
				$error("result transfer with no sample outstanding: %h", m_axis_tdata);
				error_count++;
			end else begin
				want = expected_decisions.pop_front();
				if (got.send_rate !== want.send_rate) begin
					$error("send_rate: expected %0d, got %0d", want.send_rate, got.send_rate);
					error_count++;
				end
				if (got.hold_ms !== want.hold_ms) begin
					$error("hold_ms: expected %0d, got %0d", want.hold_ms, got.hold_ms);
					error_count++;
				end
				if (got.was_bad !== want.was_bad) begin
					$error("was_bad: expected %0d, got %0d", want.was_bad, got.was_bad);
					error_count++;
				end
				if (m_axis_tdata[rars_pkg::OUT_DATA_W-1:$bits(rars_pkg::result_t)] !== '0) begin
					$error("zero fill: expected 0, got %0d",
						m_axis_tdata[rars_pkg::OUT_DATA_W-1:$bits(rars_pkg::result_t)]);
					error_count++;
				end
			end
		end
	end

	// Abandon the run when no channel has moved a transfer for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// Shadow registers and state start from the reset values.
		cfg_max_fps = rars_pkg::MAX_FPS_RST;
		cfg_limit[0] = rars_pkg::LIMIT_A_RST;
		cfg_limit[1] = rars_pkg::LIMIT_B_RST;
		cfg_limit[2] = rars_pkg::LIMIT_C_RST;
		cfg_rate[0] = rars_pkg::RATE_A_RST;
		cfg_rate[1] = rars_pkg::RATE_B_RST;
		cfg_rate[2] = rars_pkg::RATE_C_RST;
		cfg_init_hold = rars_pkg::INIT_HOLD_RST;
		st_rate = rars_pkg::MAX_FPS_RST;
		st_hold = rars_pkg::INIT_HOLD_RST;
		st_deadline = '0;
		st_armed = 1'b0;
		st_bad_seen = 1'b0;
		st_last_bad = '0;
		st_good_seen = 1'b0;
		st_good_since = '0;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_thresholds();
		test_hold_timing();
		test_register_extremes();
		test_random_traffic();
		test_backpressure();
		wait_until_quiet();

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
hdl/rars_pkg.sv
hdl/rars_regs.sv
hdl/rars_core.sv
hdl/rtt_adaptive_rate_selector.sv
bench/testbench.sv
